@@ rtl/fwa_pkg.sv @@
package fwa_pkg;

    // Field widths
    localparam int ADDR_W       = 24;
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int OP_W         = 2;
    localparam int CNT_W        = 2;
    localparam int SEC_OUT_W    = 12;
    localparam int WORD_BYTES   = 4;
    localparam int PEND_BYTES   = WORD_BYTES - 1;
    localparam int PEND_W       = PEND_BYTES * BYTE_W;

    // Flash geometry
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int SEC_W        = ADDR_W - SECTOR_SHIFT;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Output command codes
    localparam logic CMD_ERASE = 1'b0;
    localparam logic CMD_PROG  = 1'b1;

    // Results caused by one input request: optional erase, optional program
    typedef struct packed {
        logic                 erase;
        logic                 prog;
        logic [SEC_OUT_W-1:0] sector;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_W-1:0]    word;
    } t_req;

endpackage

@@ rtl/fwa_in_if.sv @@
interface fwa_in_if;
    logic                      valid;
    logic                      ready;
    logic [fwa_pkg::OP_W-1:0]  op;
    logic [fwa_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface fwa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [fwa_pkg::SEC_OUT_W-1:0] sector_index;
    logic [fwa_pkg::ADDR_W-1:0]   write_address;
    logic [fwa_pkg::WORD_W-1:0]   write_word;
    logic                         last;

    modport source (output valid, output command, output sector_index,
                    output write_address, output write_word, output last,
                    input ready);
    modport sink   (input valid, input command, input sector_index,
                    input write_address, input write_word, input last,
                    output ready);
endinterface

@@ rtl/fwa_pack.sv @@
module fwa_pack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [fwa_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    input  logic                        i_accept,
    input  logic [fwa_pkg::OP_W-1:0]    i_op,
    input  logic [fwa_pkg::BYTE_W-1:0]  i_data_byte,
    output fwa_pkg::t_req               o_req
);

    logic [fwa_pkg::ADDR_W-1:0] r_start_addr;
    logic [fwa_pkg::ADDR_W-1:0] r_next_addr, n_next_addr;
    logic [fwa_pkg::SEC_W-1:0]  r_erased_sec, n_erased_sec;
    logic                       r_erased_vld, n_erased_vld;
    logic [fwa_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [fwa_pkg::PEND_W-1:0] r_pend, n_pend;

    logic [fwa_pkg::ADDR_W-1:0] start_a;
    logic [fwa_pkg::SEC_W-1:0]  start_s;
    logic [fwa_pkg::ADDR_W-1:0] last_b;
    logic [fwa_pkg::SEC_W-1:0]  target_sec;
    logic                       need_erase;
    logic [fwa_pkg::WORD_W-1:0] pad_word;
    logic [fwa_pkg::WORD_W-1:0] emit_word;
    logic                       emit;

    // Start address (word aligned) and its sector
    assign start_a = {r_start_addr[fwa_pkg::ADDR_W-1:2], 2'b00};
    assign start_s = start_a[fwa_pkg::ADDR_W-1 -: fwa_pkg::SEC_W];

    // Sector reached by the last byte of the word at the write address
    assign last_b     = r_next_addr + fwa_pkg::ADDR_W'(fwa_pkg::WORD_BYTES - 1);
    assign target_sec = last_b[fwa_pkg::ADDR_W-1 -: fwa_pkg::SEC_W];
    assign need_erase = !r_erased_vld || (target_sec > r_erased_sec);

    // Pending bytes padded with erased-flash value above the fill count
    always_comb begin
        pad_word = {fwa_pkg::PAD_BYTE, r_pend};
        for (int i = 0; i < fwa_pkg::PEND_BYTES; i++) begin
            if (i >= int'(r_cnt)) begin
                pad_word[i*fwa_pkg::BYTE_W +: fwa_pkg::BYTE_W] = fwa_pkg::PAD_BYTE;
            end
        end
    end

    // Next state and result request
    always_comb begin
        n_next_addr  = r_next_addr;
        n_erased_sec = r_erased_sec;
        n_erased_vld = r_erased_vld;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        emit         = 1'b0;
        emit_word    = pad_word;

        case (i_op)
            fwa_pkg::OP_START: begin
                n_next_addr = start_a;
                if (start_s[fwa_pkg::SEC_W-1:0] == '0) begin
                    n_erased_vld = 1'b0;
                    n_erased_sec = '0;
                end else begin
                    n_erased_vld = 1'b1;
                    n_erased_sec = start_s[fwa_pkg::SEC_W-1:0] - 1'b1;
                end
            end
            fwa_pkg::OP_DATA: begin
                if (r_cnt == fwa_pkg::CNT_W'(fwa_pkg::PEND_BYTES)) begin
                    emit      = 1'b1;
                    emit_word = {i_data_byte, r_pend};
                end else begin
                    n_pend[r_cnt*fwa_pkg::BYTE_W +: fwa_pkg::BYTE_W] = i_data_byte;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fwa_pkg::OP_FLUSH: begin
                emit = (r_cnt != '0);
            end
            default: begin
            end
        endcase

        o_req        = '0;
        o_req.addr   = r_next_addr;
        o_req.word   = emit_word;
        o_req.sector = fwa_pkg::SEC_OUT_W'(target_sec);
        if (emit) begin
            o_req.prog  = 1'b1;
            o_req.erase = need_erase;
            n_cnt       = '0;
            n_next_addr = r_next_addr + fwa_pkg::ADDR_W'(fwa_pkg::WORD_BYTES);
            if (need_erase) begin
                n_erased_sec = target_sec;
                n_erased_vld = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= '0;
            r_next_addr  <= '0;
            r_erased_sec <= '0;
            r_erased_vld <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_addr <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_next_addr  <= n_next_addr;
                r_erased_sec <= n_erased_sec;
                r_erased_vld <= n_erased_vld;
                r_cnt        <= n_cnt;
            end
        end
    end

    // Pending byte storage, valid below the fill count only
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

@@ rtl/fwa_out.sv @@
module fwa_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  fwa_pkg::t_req i_req,
    output logic          o_can_load,
    fwa_out_if.source     o_out
);

    logic                          r_erase, n_erase;
    logic                          r_prog, n_prog;
    logic [fwa_pkg::SEC_OUT_W-1:0] r_sector;
    logic [fwa_pkg::ADDR_W-1:0]    r_addr;
    logic [fwa_pkg::WORD_W-1:0]    r_word;
    logic                          out_fire;

    assign out_fire = o_out.valid && o_out.ready;

    // Free when empty, or when the program command goes out now
    assign o_can_load = !(r_erase || r_prog) || (o_out.ready && !r_erase);

    // Erase goes out first, then the program command
    always_comb begin
        n_erase = r_erase;
        n_prog  = r_prog;
        if (out_fire) begin
            if (r_erase) begin
                n_erase = 1'b0;
            end else begin
                n_prog = 1'b0;
            end
        end
        if (i_load) begin
            n_erase = i_req.erase;
            n_prog  = i_req.prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase <= 1'b0;
            r_prog  <= 1'b0;
        end else begin
            r_erase <= n_erase;
            r_prog  <= n_prog;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sector <= i_req.sector;
            r_addr   <= i_req.addr;
            r_word   <= i_req.word;
        end
    end

    // Output mux
    assign o_out.valid         = r_erase || r_prog;
    assign o_out.command       = r_erase ? fwa_pkg::CMD_ERASE : fwa_pkg::CMD_PROG;
    assign o_out.sector_index  = r_erase ? r_sector : '0;
    assign o_out.write_address = r_erase ? '0 : r_addr;
    assign o_out.write_word    = r_erase ? '0 : r_word;
    assign o_out.last          = !r_erase;

endmodule

@@ rtl/flash_write_word_aligner_core.sv @@
// Timing: a request's first result is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the output is ready; a request that
// causes an erase and a program command holds the input until the erase is taken,
// as the single result register hands out one command per cycle.
// Reset: synchronous, active low; clears address, erase tracking, fill count,
// start address and output valid. Pending byte storage is not reset.
module flash_write_word_aligner_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [fwa_pkg::ADDR_W-1:0] i_cfg_wr_data,
    fwa_in_if.sink                     i_in,
    fwa_out_if.source                  o_out
);

    logic          can_load;
    logic          accept;
    fwa_pkg::t_req req;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    // Byte packing and erase tracking
    fwa_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_op          (i_in.op),
        .i_data_byte   (i_in.data_byte),
        .o_req         (req)
    );

    // Result register and command sequencing
    fwa_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_req      (req),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

@@ rtl/fwa_checker.sv @@
module fwa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_command,
    input logic i_out_last,
    input logic [fwa_pkg::SEC_OUT_W-1:0] i_out_sector
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An erase never closes a request's results
    a_erase_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_command == fwa_pkg::CMD_ERASE) |-> !i_out_last)
        else $error("erase marked last");

    // An accepted erase is followed by its program command
    a_erase_then_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_command == fwa_pkg::CMD_ERASE)
        |=> (i_out_valid && i_out_command == fwa_pkg::CMD_PROG))
        else $error("erase not followed by program");

    // Program command is last and carries no sector
    a_prog_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_command == fwa_pkg::CMD_PROG)
        |-> (i_out_last && i_out_sector == '0))
        else $error("program command fields wrong");

    // Input stalls while an erase waits
    a_erase_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_command == fwa_pkg::CMD_ERASE) |-> !i_in_ready)
        else $error("input ready during pending erase");

endmodule

bind flash_write_word_aligner_core fwa_checker u_fwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_command (o_out.command),
    .i_out_last    (o_out.last),
    .i_out_sector  (o_out.sector_index)
);

@@ tb/sv/fwa_checker.sv @@
`timescale 1ns / 100ps

module fwa_tb_checker
    import fwa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data,
    fwa_in_if                 i_in,
    fwa_out_if                i_out,
    output int                o_fail_cnt,
    output int                o_pending_cnt
);

    // One flash command as it leaves the block
    typedef struct packed {
        logic                 command;
        logic [SEC_OUT_W-1:0] sector_index;
        logic [ADDR_W-1:0]    write_address;
        logic [WORD_W-1:0]    write_word;
        logic                 last;
    } t_flash_cmd;

    // Shadow of the packer state
    logic [ADDR_W-1:0] start_cfg;
    logic [ADDR_W-1:0] next_addr;
    logic [SEC_W-1:0]  erased_sec;
    logic              erased_vld;
    logic [PEND_W-1:0] pend_bytes;
    logic [CNT_W-1:0]  pend_cnt;

    t_flash_cmd flash_cmds_due[$];
    int         n_fail;

    // Queue the erase (if the word reaches a new sector) and the program command
    function automatic void queue_word_program(input logic [WORD_W-1:0] word);
        logic [ADDR_W-1:0] end_addr;
        logic [SEC_W-1:0]  target;
        t_flash_cmd        cmd;
        end_addr = next_addr + ADDR_W'(WORD_BYTES - 1);
        target   = end_addr[ADDR_W-1 -: SEC_W];
        if (!erased_vld || target > erased_sec) begin
            cmd = '{CMD_ERASE, SEC_OUT_W'(target), '0, '0, 1'b0};
            flash_cmds_due.push_back(cmd);
            erased_sec = target;
            erased_vld = 1'b1;
        end
        cmd = '{CMD_PROG, '0, next_addr, word, 1'b1};
        flash_cmds_due.push_back(cmd);
        next_addr = next_addr + ADDR_W'(WORD_BYTES);
    endfunction

    // Advance the shadow state for one accepted request
    function automatic void pack_request(input logic [OP_W-1:0] op,
                                         input logic [BYTE_W-1:0] data);
        logic [ADDR_W-1:0] aligned;
        logic [SEC_W-1:0]  sec;
        logic [WORD_W-1:0] padded;
        logic [WORD_W-1:0] word;
        case (op)
            OP_START: begin
                // low two address bits are dropped
                aligned   = {start_cfg[ADDR_W-1:2], 2'b00};
                sec       = aligned[ADDR_W-1 -: SEC_W];
                next_addr = aligned;
                if (sec == '0) begin
                    erased_vld = 1'b0;
                    erased_sec = '0;
                end else begin
                    erased_vld = 1'b1;
                    erased_sec = sec - 1'b1;
                end
            end
            OP_DATA: begin
                if (pend_cnt < CNT_W'(PEND_BYTES)) begin
                    pend_bytes[BYTE_W*pend_cnt +: BYTE_W] = data;
                    pend_cnt = pend_cnt + 1'b1;
                end else begin
                    word       = {data, pend_bytes};
                    pend_bytes = '0;
                    pend_cnt   = '0;
                    queue_word_program(word);
                end
            end
            OP_FLUSH: begin
                // pad the unfilled byte lanes, nothing to do when empty
                if (pend_cnt != '0) begin
                    padded = {PAD_BYTE, pend_bytes};
                    for (int i = 0; i < WORD_BYTES; i++) begin
                        word[BYTE_W*i +: BYTE_W] = (i < pend_cnt) ?
                            padded[BYTE_W*i +: BYTE_W] : PAD_BYTE;
                    end
                    pend_bytes = '0;
                    pend_cnt   = '0;
                    queue_word_program(word);
                end
            end
            default: begin
                // unused op code: ignored
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_val,
                                        input logic [WORD_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            n_fail++;
        end
    endfunction

    // Monitor: results are checked before the same edge's request is predicted
    always @(posedge i_clk) begin
        t_flash_cmd exp_cmd;
        if (!i_rst_n) begin
            start_cfg  = '0;
            next_addr  = '0;
            erased_sec = '0;
            erased_vld = 1'b0;
            pend_bytes = '0;
            pend_cnt   = '0;
            flash_cmds_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (flash_cmds_due.size() == 0) begin
                    $error("flash command with no request pending: command %0d addr 0x%0h",
                           i_out.command, i_out.write_address);
                    n_fail++;
                end else begin
                    exp_cmd = flash_cmds_due.pop_front();
                    check_field("command", WORD_W'(exp_cmd.command), WORD_W'(i_out.command));
                    check_field("sector_index", WORD_W'(exp_cmd.sector_index),
                                WORD_W'(i_out.sector_index));
                    check_field("write_address", WORD_W'(exp_cmd.write_address),
                                WORD_W'(i_out.write_address));
                    check_field("write_word", exp_cmd.write_word, i_out.write_word);
                    check_field("last", WORD_W'(exp_cmd.last), WORD_W'(i_out.last));
                end
            end
            if (i_in.valid && i_in.ready) begin
                pack_request(i_in.op, i_in.data_byte);
            end
            if (i_cfg_wr_en) begin
                start_cfg = i_cfg_wr_data;
            end
        end
        o_fail_cnt    <= n_fail;
        o_pending_cnt <= flash_cmds_due.size();
    end

endmodule

@@ tb/sv/tb_flash_write_word_aligner_core.sv @@
`timescale 1ns / 100ps

module tb_flash_write_word_aligner_core;
    import fwa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEG_ITEMS    = 120;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [ADDR_W-1:0] i_cfg_wr_data;
    int                src_idle_pct;
    int                snk_idle_pct;
    int                fail_cnt;
    int                pending_cnt;

    fwa_in_if  in_if();
    fwa_out_if out_if();

    flash_write_word_aligner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    fwa_tb_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .i_out         (out_if),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    always #5 i_clk = ~i_clk;

    // Output backpressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: cycles without any handshake
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // Present one request, returns at the edge where it is accepted
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.data_byte <= data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Wait until every expected command is out and the block has settled
    task automatic drain_commands();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_addr(input logic [ADDR_W-1:0] addr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] cfg;
        logic [31:0]       addr_sum;
        int                r;

        in_if.valid     <= 1'b0;
        in_if.op        <= OP_START;
        in_if.data_byte <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_rst_n         <= 1'b0;
        src_idle_pct = 35;
        snk_idle_pct = 61;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes before any start: word at address 0, sector 0 erased first
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_DATA, 8'hA5);
        send_request(OP_DATA, 8'h5A);
        // empty flush and unused op code
        send_request(OP_FLUSH, 8'h00);
        send_request(OP_UNUSED, 8'hFF);
        // partial words padded with 0xFF
        send_request(OP_DATA, 8'h3C);
        send_request(OP_FLUSH, 8'hFF);
        send_request(OP_DATA, 8'h81);
        send_request(OP_DATA, 8'h7E);
        send_request(OP_DATA, 8'hC3);
        send_request(OP_FLUSH, 8'h00);

        // Unaligned start with bytes pending; first word ends up in sector 1
        drain_commands();
        write_start_addr(24'h001FFE);
        send_request(OP_DATA, 8'h11);
        send_request(OP_DATA, 8'h22);
        send_request(OP_START, 8'h00);
        send_request(OP_DATA, 8'h33);
        send_request(OP_DATA, 8'h44);

        // Top of flash: address wraps to 0 with no erase
        drain_commands();
        write_start_addr(24'hFFFFFC);
        send_request(OP_START, 8'hFF);
        for (int i = 0; i < 8; i++) begin
            send_request(OP_DATA, 8'($urandom));
        end

        // Random part: three idle patterns, several start addresses each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 35;
                    snk_idle_pct = 61;
                end
                1: begin
                    src_idle_pct = 61;
                    snk_idle_pct = 35;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                if (seg == 0) begin
                    cfg = (ph == 0) ? 24'h000000 : (ph == 1) ? 24'hFFFFFF : 24'hFFFFFC;
                end else begin
                    case ($urandom_range(3))
                        0: begin
                            // at or just below a sector boundary, maybe unaligned
                            addr_sum = ($urandom_range(1, 4095) << SECTOR_SHIFT)
                                       - 4 * $urandom_range(0, 12) + $urandom_range(0, 3);
                            cfg = addr_sum[ADDR_W-1:0];
                        end
                        1: cfg = 24'hFFFFFC - ADDR_W'(4 * $urandom_range(0, 10));
                        2: cfg = ADDR_W'($urandom);
                        default: cfg = ADDR_W'($urandom_range(0, 64));
                    endcase
                end
                drain_commands();
                write_start_addr(cfg);
                for (int i = 0; i < SEG_ITEMS; i++) begin
                    if (i == 0 && $urandom_range(9) != 0) begin
                        op = OP_START;
                    end else begin
                        r  = $urandom_range(99);
                        op = (r < 86) ? OP_DATA : (r < 93) ? OP_FLUSH :
                             (r < 97) ? OP_START : OP_UNUSED;
                    end
                    send_request(op, 8'($urandom));
                end
            end
        end

        drain_commands();
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
